FILE: rtl/handle_table_refcount_lease_assert.svh
// assertion macros shared by the handle table checker
// no dependencies; included by files that carry concurrent assertions
`ifndef HANDLE_TABLE_REFCOUNT_LEASE_ASSERT_SVH
`define HANDLE_TABLE_REFCOUNT_LEASE_ASSERT_SVH

// same-cycle implication under reset
`define HTRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define HTRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/htrl_pkg.sv
// package for the reference-counted handle table: codes, types, defaults
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package htrl_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned OWNER_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned REFS_W = 16;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned OP_W = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd180;
  localparam logic [REFS_W-1:0] REFS_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_DEL = 3'd3;
  localparam logic [OP_W-1:0] OP_PURGE = 3'd4;
  localparam logic [OP_W-1:0] OP_COLLECT = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] ST_OWNER = 3'd4;
  localparam logic [STAT_W-1:0] ST_DELETED = 3'd5;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [REFS_W-1:0]  refs;
    logic [TIME_W-1:0]  last_use;
    logic               deleted;
  } slot_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

FILE: rtl/handle_table_refcount_lease.sv
// handle table top level: valid flops, slot memory, operation sequencer; depends on htrl_pkg
// find, release, mark deleted, purge: slot read at accept, updated and written back in S_RMW,
//   result word sent from S_DONE; a new item is accepted only once back in S_IDLE
// allocate: walk to the first free slot, on a full table sweep and walk again; collect: one sweep
// slot walks read the valid flops, the sweep reads one memory slot per cycle
// reset clears the valid flops and loads timeout_r with 180; no clearing pass
`timescale 1ns / 1ps

module handle_table_refcount_lease
  import htrl_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot_index, owner_id, now_time, zero pad
  input  logic [OP_W-1:0]       in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_slot, ref_count, collected_count, zero pad
  output logic [STAT_W-1:0]     out_tuser,  // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIME_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

  slot_ent_t mem [SLOT_COUNT];
  slot_ent_t rd_data_r;
  slot_ent_t wr_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;

  state_t state_r, state_nxt;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;
  logic [TIME_W-1:0]     timeout_r;

  logic [OP_W-1:0]    op_r, op_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;

  logic [AW-1:0]    k_r, k_nxt;
  logic             issued_r, issued_nxt;
  logic             swept_r, swept_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [AW-1:0]    pk_r, pk_nxt;

  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic [REFS_W-1:0] res_refs_r, res_refs_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]  out_slot_r, out_slot_nxt;
  logic [REFS_W-1:0] out_refs_r, out_refs_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [IDX_W-1:0] in_idx;
  logic [XW-1:0]    in_idx_x;
  logic             in_fire;
  logic [REFS_W-1:0] dec_refs;
  logic [TIME_W-1:0] idle_age;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_idx_x  = XW'(in_idx);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_refs_r, out_slot_r};

  assign dec_refs = (rd_data_r.refs != '0) ? rd_data_r.refs - 16'd1 : '0;
  assign idle_age = now_r - rd_data_r.last_use;

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    owner_r    <= owner_nxt;
    now_r      <= now_nxt;
    k_r        <= k_nxt;
    issued_r   <= issued_nxt;
    swept_r    <= swept_nxt;
    cnt_r      <= cnt_nxt;
    pk_r       <= pk_nxt;
    res_stat_r <= res_stat_nxt;
    res_slot_r <= res_slot_nxt;
    res_refs_r <= res_refs_nxt;
    out_stat_r <= out_stat_nxt;
    out_slot_r <= out_slot_nxt;
    out_refs_r <= out_refs_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    owner_nxt     = owner_r;
    now_nxt       = now_r;
    k_nxt         = k_r;
    issued_nxt    = issued_r;
    swept_nxt     = swept_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pk_nxt        = pk_r;
    res_stat_nxt  = res_stat_r;
    res_slot_nxt  = res_slot_r;
    res_refs_nxt  = res_refs_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_slot_nxt  = out_slot_r;
    out_refs_nxt  = out_refs_r;
    out_cnt_nxt   = out_cnt_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data_r;
    rd_addr       = in_idx_x[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_tuser;
          addr_nxt     = in_idx_x[AW-1:0];
          owner_nxt    = in_tdata[IDX_W +: OWNER_W];
          now_nxt      = in_tdata[IDX_W + OWNER_W +: TIME_W];
          k_nxt        = '0;
          issued_nxt   = 1'b0;
          swept_nxt    = 1'b0;
          cnt_nxt      = '0;
          res_stat_nxt = ST_OK;
          res_slot_nxt = '0;
          res_refs_nxt = '0;
          case (in_tuser)
            OP_ALLOC: begin
              state_nxt = S_SCAN;
            end
            OP_COLLECT: begin
              state_nxt = S_SWEEP;
            end
            OP_FIND, OP_RELEASE, OP_MARK_DEL, OP_PURGE: begin
              res_slot_nxt = in_idx;
              if (in_idx_x >= XW'(SLOT_COUNT)) begin
                res_stat_nxt = ST_RANGE;
                state_nxt    = S_DONE;
              end else if (!valid_r[in_idx_x[AW-1:0]]) begin
                res_stat_nxt = ST_EMPTY;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_RMW;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RMW: begin
        state_nxt = S_DONE;
        wr_addr   = addr_r;
        case (op_r)
          OP_FIND: begin
            if (rd_data_r.owner != owner_r) begin
              res_stat_nxt = ST_OWNER;
            end else if (rd_data_r.deleted) begin
              res_stat_nxt = ST_DELETED;
            end else begin
              wr_en            = 1'b1;
              wr_data.refs     = (rd_data_r.refs != REFS_MAX) ? rd_data_r.refs + 16'd1
                                                              : rd_data_r.refs;
              wr_data.last_use = now_r;
              res_refs_nxt     = wr_data.refs;
            end
          end
          OP_RELEASE: begin
            wr_en        = 1'b1;
            wr_data.refs = dec_refs;
            if ((dec_refs == '0) && rd_data_r.deleted) begin
              valid_nxt[addr_r] = 1'b0;
            end else begin
              res_refs_nxt = dec_refs;
            end
          end
          OP_MARK_DEL: begin
            wr_en           = 1'b1;
            wr_data.deleted = 1'b1;
            res_refs_nxt    = rd_data_r.refs;
          end
          default: begin
            if (rd_data_r.refs == '0) begin
              valid_nxt[addr_r] = 1'b0;
            end else begin
              wr_en           = 1'b1;
              wr_data.deleted = 1'b1;
              res_refs_nxt    = rd_data_r.refs;
            end
          end
        endcase
      end

      S_SCAN: begin
        if (!valid_r[k_r]) begin
          wr_en             = 1'b1;
          wr_addr           = k_r;
          wr_data.owner     = owner_r;
          wr_data.refs      = 16'd1;
          wr_data.last_use  = now_r;
          wr_data.deleted   = 1'b0;
          valid_nxt[k_r]    = 1'b1;
          res_stat_nxt      = ST_OK;
          res_slot_nxt      = IDX_W'(k_r);
          res_refs_nxt      = 16'd1;
          state_nxt         = S_DONE;
        end else if (k_r == LAST_SLOT) begin
          if (swept_r) begin
            res_stat_nxt = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            k_nxt      = '0;
            issued_nxt = 1'b0;
            state_nxt  = S_SWEEP;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_SWEEP: begin
        rd_addr = k_r;
        if (!issued_r) begin
          pv_nxt = 1'b1;
          pk_nxt = k_r;
          if (k_r == LAST_SLOT) begin
            issued_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (pv_r && valid_r[pk_r] && (rd_data_r.refs == '0) &&
            (rd_data_r.deleted || (idle_age > timeout_r))) begin
          valid_nxt[pk_r] = 1'b0;
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (issued_r && !pv_r) begin
          if (op_r == OP_ALLOC) begin
            swept_nxt = 1'b1;
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_slot_nxt  = res_slot_r;
          out_refs_nxt  = res_refs_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/htrl_checker.sv
// port-level checker for the handle table, attached by bind
// depends on htrl_pkg and handle_table_refcount_lease_assert.svh
`timescale 1ns / 1ps
`include "handle_table_refcount_lease_assert.svh"

module htrl_checker
  import htrl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  `HTRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")
  `HTRL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while an item is in work")
  `HTRL_ASSERT_NOW(a_refs_on_error, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata[21:6] == 16'd0, "nonzero ref count on failed word")
  `HTRL_ASSERT_NOW(a_count_source, clk, rst_n, out_tvalid && (out_tuser != ST_OK) && (out_tuser != ST_FULL), out_tdata[28:22] == 7'd0, "collected count on an operation without sweep")

endmodule

bind handle_table_refcount_lease htrl_checker u_htrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
